### rtl/tarc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tarc_pkg
// Shared types and constants for the triangle aspect-ratio check unit.
// ----------------------------------------------------------------------------
package tarc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int OUT_BITS      = 24;
    localparam int QUOT_BITS     = 2 * OUT_BITS;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // register word indexes
    localparam logic REG_MAX_ASPECT = 1'b0;

    localparam logic [OUT_BITS-1:0] MAX_ASPECT_RST = OUT_BITS'(5120);
    localparam logic [OUT_BITS-1:0] ASPECT_SAT     = '1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] aspect;
        logic                exceeds_limit;
        logic                degenerate;
    } tri_out_t;

    // side flags that ride along the divider and root pipelines
    typedef struct packed {
        logic sat;
        logic deg;
    } tri_flags_t;

endpackage

### rtl/triangle_aspect_ratio_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_aspect_ratio_check_unit
// Aspect ratio of a 3D triangle in Q16.8, checked against a programmable limit.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one triangle (three vertices) per transaction, valid/ready.
//   m_ channel: one result per triangle, in order: aspect (Q16.8, saturated),
//               exceeds_limit and degenerate.
//   APB port: register 0 at byte address 0 holds max_aspect_ratio (24 bits).
//   Pipeline: 80 register stages: 7 arithmetic stages, 48 restoring-division
//   stages (one quotient bit each), 24 square-root stages (one root bit each)
//   and the output register.
//   Throughput is one triangle per cycle while s_ready is high; the
//   bit-per-stage divider and root pipelines set the depth, not the rate.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the limit
//   with 20.0. When the receiver stalls, a result moves into a skid register
//   and the pipeline keeps taking one more transaction; with the skid full
//   the whole pipeline holds and s_ready drops, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_aspect_ratio_check_unit #(
    parameter int FRAC_BITS = tarc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tarc_pkg::tri_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tarc_pkg::tri_out_t                  m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tarc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tarc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tarc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tarc_pkg::*;

    localparam int D   = COORD_BITS + 1;       // edge component width
    localparam int SQW = 2 * D;                // product width
    localparam int LW  = 2 * D + 1;            // squared length / cross comp
    localparam int AW  = 2 * LW + 2;           // squared area
    localparam int NW  = 2 * LW + 2 * FRAC_BITS;
    localparam int QB  = QUOT_BITS;
    localparam int CW  = (NW > AW + QB) ? NW : AW + QB;
    localparam int HB  = QB / 2;

    // ---------------- configuration ----------------
    logic [OUT_BITS-1:0] max_aspect_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_aspect_reg <= MAX_ASPECT_RST;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_MAX_ASPECT) begin
            max_aspect_reg <= pwdata[OUT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_ASPECT) begin
            prdata = APB_DATA_W'(max_aspect_reg);
        end
    end

    // ---------------- pipeline enable / skid ----------------
    logic     en;
    logic     out_valid_reg, skid_valid_reg;
    logic     out_valid_next, skid_valid_next;
    tri_out_t out_data_reg, skid_data_reg;
    tri_out_t fin_data;
    logic     fin_valid;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- stage 1: edge vectors ----------------
    logic              v1_reg;
    logic signed [D-1:0] d0x_reg, d0y_reg, d0z_reg;
    logic signed [D-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [D-1:0] d1x_reg, d1y_reg, d1z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0x_reg <= D'(s_data.a_x) - D'(s_data.b_x);
            d0y_reg <= D'(s_data.a_y) - D'(s_data.b_y);
            d0z_reg <= D'(s_data.a_z) - D'(s_data.b_z);
            e1x_reg <= D'(s_data.b_x) - D'(s_data.c_x);
            e1y_reg <= D'(s_data.b_y) - D'(s_data.c_y);
            e1z_reg <= D'(s_data.b_z) - D'(s_data.c_z);
            d1x_reg <= D'(s_data.c_x) - D'(s_data.a_x);
            d1y_reg <= D'(s_data.c_y) - D'(s_data.a_y);
            d1z_reg <= D'(s_data.c_z) - D'(s_data.a_z);
        end
    end

    // ---------------- stage 2: component products ----------------
    logic                  v2_reg;
    logic signed [SQW-1:0] s0x_reg, s0y_reg, s0z_reg;
    logic signed [SQW-1:0] s1x_reg, s1y_reg, s1z_reg;
    logic signed [SQW-1:0] s2x_reg, s2y_reg, s2z_reg;
    logic signed [SQW-1:0] cxa_reg, cxb_reg, cya_reg, cyb_reg, cza_reg, czb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0x_reg <= d0x_reg * d0x_reg;
            s0y_reg <= d0y_reg * d0y_reg;
            s0z_reg <= d0z_reg * d0z_reg;
            s1x_reg <= e1x_reg * e1x_reg;
            s1y_reg <= e1y_reg * e1y_reg;
            s1z_reg <= e1z_reg * e1z_reg;
            s2x_reg <= d1x_reg * d1x_reg;
            s2y_reg <= d1y_reg * d1y_reg;
            s2z_reg <= d1z_reg * d1z_reg;
            cxa_reg <= d0y_reg * d1z_reg;
            cxb_reg <= d0z_reg * d1y_reg;
            cya_reg <= d0z_reg * d1x_reg;
            cyb_reg <= d0x_reg * d1z_reg;
            cza_reg <= d0x_reg * d1y_reg;
            czb_reg <= d0y_reg * d1x_reg;
        end
    end

    // ---------------- stage 3: lengths and cross product ----------------
    logic                 v3_reg;
    logic [LW-1:0]        len0_reg, len1_reg, len2_reg;
    logic signed [LW-1:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len0_reg <= LW'(unsigned'(s0x_reg)) + LW'(unsigned'(s0y_reg))
                      + LW'(unsigned'(s0z_reg));
            len1_reg <= LW'(unsigned'(s1x_reg)) + LW'(unsigned'(s1y_reg))
                      + LW'(unsigned'(s1z_reg));
            len2_reg <= LW'(unsigned'(s2x_reg)) + LW'(unsigned'(s2y_reg))
                      + LW'(unsigned'(s2z_reg));
            px_reg   <= LW'(cxa_reg) - LW'(cxb_reg);
            py_reg   <= LW'(cya_reg) - LW'(cyb_reg);
            pz_reg   <= LW'(cza_reg) - LW'(czb_reg);
        end
    end

    // ---------------- stage 4: longest edge, magnitudes ----------------
    logic          v4_reg;
    logic [LW-1:0] lmax_reg, mx_reg, my_reg, mz_reg;
    logic [LW-1:0] lmax01;

    assign lmax01 = (len1_reg > len0_reg) ? len1_reg : len0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lmax_reg <= (len2_reg > lmax01) ? len2_reg : lmax01;
            mx_reg   <= px_reg[LW-1] ? LW'(-px_reg) : LW'(px_reg);
            my_reg   <= py_reg[LW-1] ? LW'(-py_reg) : LW'(py_reg);
            mz_reg   <= pz_reg[LW-1] ? LW'(-pz_reg) : LW'(pz_reg);
        end
    end

    // ---------------- stage 5: squares ----------------
    logic            v5_reg;
    logic [2*LW-1:0] ll_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= lmax_reg * lmax_reg;
            qx_reg <= mx_reg * mx_reg;
            qy_reg <= my_reg * my_reg;
            qz_reg <= mz_reg * mz_reg;
        end
    end

    // ---------------- stage 6: area sum and scaled numerator ----------------
    logic          v6_reg;
    logic [AW-1:0] area6_reg;
    logic [CW-1:0] num6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            area6_reg <= AW'(qx_reg) + AW'(qy_reg) + AW'(qz_reg);
            num6_reg  <= CW'(ll_reg) << (2 * FRAC_BITS);
        end
    end

    // ---------------- stage 7: saturation and zero-area detect ----------------
    logic          dv_reg   [0:QB];
    logic [CW-1:0] drem_reg [0:QB];
    logic [AW-1:0] darea_reg[0:QB];
    logic [QB-1:0] dq_reg   [0:QB];
    tri_flags_t    dflg_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            drem_reg[0]     <= num6_reg;
            darea_reg[0]    <= area6_reg;
            dq_reg[0]       <= '0;
            dflg_reg[0].deg <= (area6_reg == '0);
            dflg_reg[0].sat <= (num6_reg >= (CW'(area6_reg) << QB));
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BIT = QB - 1 - k;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = CW'(darea_reg[k]) << BIT;
        assign take  = (drem_reg[k] >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[k+1]  <= take ? (drem_reg[k] - trial) : drem_reg[k];
                darea_reg[k+1] <= darea_reg[k];
                dq_reg[k+1]    <= dq_reg[k] | (take ? (QB'(1) << BIT) : '0);
                dflg_reg[k+1]  <= dflg_reg[k];
            end
        end
    end

    // ---------------- digit-by-digit square root, one root bit per stage ----------------
    logic          rv_reg  [1:HB];
    logic [QB-1:0] rrem_reg[1:HB];
    logic [QB-1:0] rres_reg[1:HB];
    tri_flags_t    rflg_reg[1:HB];

    for (genvar k = 0; k < HB; k++) begin : g_sqrt
        localparam int SH = QB - 2 - 2 * k;
        logic          src_v;
        logic [QB-1:0] src_rem;
        logic [QB-1:0] src_res;
        tri_flags_t    src_flg;
        logic [QB:0]   cand;
        logic          take;

        // first root stage takes the quotient straight from the divider
        if (k == 0) begin : g_first
            assign src_v   = dv_reg[QB];
            assign src_rem = dq_reg[QB];
            assign src_res = '0;
            assign src_flg = dflg_reg[QB];
        end else begin : g_chain
            assign src_v   = rv_reg[k];
            assign src_rem = rrem_reg[k];
            assign src_res = rres_reg[k];
            assign src_flg = rflg_reg[k];
        end

        assign cand = {1'b0, src_res} + ((QB + 1)'(1) << SH);
        assign take = ({1'b0, src_rem} >= cand);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[k+1] <= 1'b0;
            end else if (en) begin
                rv_reg[k+1] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rrem_reg[k+1] <= take ? QB'({1'b0, src_rem} - cand) : src_rem;
                rres_reg[k+1] <= take ? ((src_res >> 1) | (QB'(1) << SH))
                                      : (src_res >> 1);
                rflg_reg[k+1] <= src_flg;
            end
        end
    end

    // ---------------- final result and limit compare ----------------
    logic [OUT_BITS-1:0] fin_aspect;

    assign fin_valid  = rv_reg[HB];
    assign fin_aspect = (rflg_reg[HB].sat || rflg_reg[HB].deg)
                      ? ASPECT_SAT : rres_reg[HB][OUT_BITS-1:0];

    always_comb begin
        fin_data.aspect        = fin_aspect;
        fin_data.degenerate    = rflg_reg[HB].deg;
        fin_data.exceeds_limit = rflg_reg[HB].deg || (fin_aspect > max_aspect_reg);
    end

    // ---------------- output register with skid ----------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (en && fin_valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_ready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (en && fin_valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_data_reg <= fin_data;
            end else begin
                out_data_reg <= fin_data;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### test/tb_triangle_aspect_ratio_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_aspect_ratio_check_unit
// Self-checking testbench for the triangle aspect-ratio check unit.
// ----------------------------------------------------------------------------
// Triangles are sent over the s_ channel. Each accepted transaction is
// predicted exactly in wide integer arithmetic and queued. Every m_
// transaction is checked field by field against the oldest queued result.
// The limit register is reprogrammed over APB between phases, once the
// pipeline has drained. Both sides insert random idle bursts, the receiver
// holds off long enough to fill the pipeline, and the last phase runs with
// no idling at all.
// ----------------------------------------------------------------------------
module tb_triangle_aspect_ratio_check_unit;
    import tarc_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int WATCHDOG    = 5000;
    localparam int HOLD_CYCLES = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    tri_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    tri_out_t              m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tri_out_t              expected_results[$];
    logic [OUT_BITS-1:0]   aspect_limit = MAX_ASPECT_RST;
    int                    errors = 0;
    int                    stall_cycles = 0;
    bit                    idling_on = 1'b1;
    bit                    hold_request = 1'b0;

    triangle_aspect_ratio_check_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // bitwise integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = '0;
        b    = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // expected aspect ratio and flags for one triangle
    function automatic tri_out_t triangle_aspect(input tri_in_t t);
        longint      ax, ay, az, bx, by, bz, cx, cy, cz;
        longint      d0x, d0y, d0z, d1x, d1y, d1z, ex, ey, ez;
        longint      px, py, pz;
        longint      len, tmp;
        logic [127:0] mx, my, mz, area, num, q;
        tri_out_t    r;
        ax = longint'(t.a_x); ay = longint'(t.a_y); az = longint'(t.a_z);
        bx = longint'(t.b_x); by = longint'(t.b_y); bz = longint'(t.b_z);
        cx = longint'(t.c_x); cy = longint'(t.c_y); cz = longint'(t.c_z);
        d0x = ax - bx; d0y = ay - by; d0z = az - bz;
        d1x = cx - ax; d1y = cy - ay; d1z = cz - az;
        ex  = bx - cx; ey  = by - cy; ez  = bz - cz;
        len = d0x * d0x + d0y * d0y + d0z * d0z;
        tmp = ex * ex + ey * ey + ez * ez;
        if (tmp > len) len = tmp;
        tmp = d1x * d1x + d1y * d1y + d1z * d1z;
        if (tmp > len) len = tmp;
        px = d0y * d1z - d0z * d1y;
        py = d0z * d1x - d0x * d1z;
        pz = d0x * d1y - d0y * d1x;
        mx = 128'(px < 0 ? -px : px);
        my = 128'(py < 0 ? -py : py);
        mz = 128'(pz < 0 ? -pz : pz);
        area = mx * mx + my * my + mz * mz;
        if (area == 0) begin
            r.aspect        = ASPECT_SAT;
            r.exceeds_limit = 1'b1;
            r.degenerate    = 1'b1;
            return r;
        end
        num = (128'(len) * 128'(len)) << (2 * FRAC);
        if (num >= (area << (2 * OUT_BITS))) begin
            r.aspect = ASPECT_SAT;
        end else begin
            q = num / area;
            r.aspect = OUT_BITS'(int_sqrt(q[63:0]));
        end
        r.exceeds_limit = r.aspect > aspect_limit;
        r.degenerate    = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // one triangle transaction, with an optional idle burst before it
    task automatic send_triangle(input tri_in_t t);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        expected_results = {expected_results, triangle_aspect(t)};
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // APB write, setup then access cycle; pipeline must be empty
    task automatic write_limit(input logic [APB_DATA_W-1:0] value);
        drain_results();
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'(REG_MAX_ASPECT) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        aspect_limit = value[OUT_BITS-1:0];
        @(posedge aclk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input int span);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (sel < 4) return COORD_BITS'($urandom);
        return COORD_BITS'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic tri_in_t random_triangle();
        tri_in_t     t;
        int          span;
        int          k;
        int unsigned kind;
        span = 1 << $urandom_range(2, 14);
        t.a_x = pick_coord(span); t.a_y = pick_coord(span); t.a_z = pick_coord(span);
        t.b_x = pick_coord(span); t.b_y = pick_coord(span); t.b_z = pick_coord(span);
        t.c_x = pick_coord(span); t.c_y = pick_coord(span); t.c_z = pick_coord(span);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // collinear: c on the line through a and b (wraps allowed)
            k = $urandom_range(0, 4) - 2;
            t.c_x = COORD_BITS'(t.a_x + k * (t.b_x - t.a_x));
            t.c_y = COORD_BITS'(t.a_y + k * (t.b_y - t.a_y));
            t.c_z = COORD_BITS'(t.a_z + k * (t.b_z - t.a_z));
        end else if (kind == 1) begin
            // sliver: c nearly on the segment, off by one step
            t.c_x = t.a_x + (t.b_x - t.a_x) / 2 + COORD_BITS'($urandom_range(0, 2) - 1);
            t.c_y = t.a_y + (t.b_y - t.a_y) / 2 + COORD_BITS'($urandom_range(0, 2) - 1);
            t.c_z = t.a_z + (t.b_z - t.a_z) / 2;
        end else if (kind == 2) begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end
        return t;
    endfunction

    function automatic tri_in_t make_tri(input int v[9]);
        tri_in_t t;
        t.a_x = COORD_BITS'(v[0]); t.a_y = COORD_BITS'(v[1]); t.a_z = COORD_BITS'(v[2]);
        t.b_x = COORD_BITS'(v[3]); t.b_y = COORD_BITS'(v[4]); t.b_z = COORD_BITS'(v[5]);
        t.c_x = COORD_BITS'(v[6]); t.c_y = COORD_BITS'(v[7]); t.c_z = COORD_BITS'(v[8]);
        return t;
    endfunction

    // result checker
    always @(posedge aclk) begin
        tri_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, aspect", m_data.aspect, -1);
            end else begin
                want = expected_results.pop_front();
                if (m_data.aspect !== want.aspect)
                    report_mismatch("aspect", m_data.aspect, want.aspect);
                if (m_data.exceeds_limit !== want.exceeds_limit)
                    report_mismatch("exceeds_limit", m_data.exceeds_limit, want.exceeds_limit);
                if (m_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", m_data.degenerate, want.degenerate);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (idling_on && aresetn && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_triangle(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_triangle(make_tri('{-32768, -32768, -32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768}));
        send_triangle(make_tri('{0, 0, 0, 4, 0, 0, 0, 3, 0}));
        send_triangle(make_tri('{0, 0, 0, 10, 0, 0, 5, 9, 0}));
        send_triangle(make_tri('{1, 2, 3, 2, 4, 6, 3, 6, 9}));
        send_triangle(make_tri('{-32768, 0, 0, 32767, 0, 0, 0, 1, 0}));
        send_triangle(make_tri('{-32768, -32768, 0, 32767, 32767, 0, 32766, 32767, 0}));
        send_triangle(make_tri('{-32768, -32768, -32768, 32767, 32767, 32767,
                                 32767, -32768, 0}));
        send_triangle(make_tri('{32767, 32767, 32767, -32768, -32768, -32768,
                                 -32768, 32767, -32768}));
        send_triangle(make_tri('{0, 0, 0, 100, 0, 0, 50, 1, 0}));
        send_triangle(make_tri('{0, 0, 0, 1000, 0, 0, 500, 1, 0}));
        send_triangle(make_tri('{0, 0, 0, 0, 0, 7, 0, 0, -7}));
        send_triangle(make_tri('{5, -5, 5, -5, 5, -5, 5, 5, -5}));
        send_triangle(make_tri('{0, 0, 0, 40, 0, 0, 20, 1, 0}));
        send_triangle(make_tri('{0, 0, 0, 39, 0, 0, 20, 1, 0}));
        send_triangle(make_tri('{-1, -1, -1, 1, 1, 1, -1, 1, -1}));
    endtask

    task automatic test_random_phase(input int count);
        repeat (count) send_triangle(random_triangle());
    endtask

    task automatic test_limit_settings();
        write_limit(32'd0);
        test_directed();
        test_random_phase(120);
        write_limit(32'h00FF_FFFF);
        send_triangle(make_tri('{-32768, -32768, 0, 32767, 32767, 0, 32766, 32767, 0}));
        test_directed();
        test_random_phase(120);
        write_limit(32'hFF00_0A00);
        test_random_phase(80);
        write_limit(32'd256);
        test_random_phase(80);
        write_limit($urandom);
        test_random_phase(80);
        write_limit(32'(MAX_ASPECT_RST));
    endtask

    task automatic test_backpressure();
        drain_results();
        @(posedge aclk);
        hold_request = 1'b1;
        test_random_phase(150);
    endtask

    task automatic test_sender_pause();
        test_random_phase(40);
        drain_results();
        test_random_phase(40);
    endtask

    task automatic test_no_idling();
        drain_results();
        idling_on = 1'b0;
        test_random_phase(120);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(60);
        test_limit_settings();
        test_backpressure();
        test_sender_pause();
        test_no_idling();
        drain_results();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
